@@ rtl/lwfc_pkg.sv @@
`timescale 1ns / 1ps
package lwfc_pkg;

    localparam int SCAN_POINTS = 360;
    localparam int IDX_W = 9;
    localparam int DIST_W = 14;
    localparam logic [DIST_W-1:0] NOTHING = 14'h3FFF;
    localparam logic [IDX_W-1:0] LEFT_LO = 9'd270;
    localparam logic [IDX_W-1:0] CENTRE_LO = 9'd330;
    localparam logic [IDX_W-1:0] RIGHT_LO = 9'd30;
    localparam logic [IDX_W-1:0] RIGHT_HI = 9'd90;

    typedef enum logic [2:0] {
        REG_FOLLOW = 3'd0,
        REG_SAFE = 3'd1,
        REG_CORNER = 3'd2,
        REG_CRUISE = 3'd3,
        REG_TURN = 3'd4,
        REG_DOORWAY = 3'd5,
        REG_REPEATS = 3'd6,
        REG_WAIT = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        SIDE_LEFT = 2'd0,
        SIDE_CENTRE = 2'd1,
        SIDE_RIGHT = 2'd2,
        SIDE_NONE = 2'd3
    } side_t;

    typedef enum logic [1:0] {
        MODE_STRAIGHT = 2'd0,
        MODE_WALL = 2'd1,
        MODE_CORNER = 2'd2,
        MODE_WALL_ALT = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_SWEEP,
        ST_PLAN,
        ST_OUT0,
        ST_OUT1
    } state_t;

    typedef struct packed {
        logic [8:0] point_index;
        logic [13:0] range_mm;
        logic range_valid;
        logic last_point;
    } point_t;

    typedef struct packed {
        logic signed [10:0] linear_speed;
        logic signed [11:0] angular_rate;
        logic [11:0] wait_before_ms;
        logic last_command;
    } cmd_t;

    typedef struct packed {
        logic [13:0] track_mm;
        logic [13:0] guard_mm;
        logic [13:0] corner_delta;
        logic [9:0] cruise_speed;
        logic [9:0] yaw_rate;
        logic [9:0] doorway_speed;
        logic [3:0] scan_repeats;
        logic [11:0] turn_wait_ms;
    } cfg_t;

    typedef struct packed {
        logic store_en;
        logic sweep_start;
        logic sweep_en;
        logic plan_en;
        logic sel_second;
    } ctl_t;

    typedef struct packed {
        logic sweep_done;
        logic [1:0] cmd_count;
    } sts_t;

endpackage

@@ rtl/lwfc_datapath.sv @@
`timescale 1ns / 1ps
module lwfc_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  lwfc_pkg::cfg_t  cfg,
    input  lwfc_pkg::point_t pt,
    input  lwfc_pkg::ctl_t  ctl,
    output lwfc_pkg::sts_t  sts,
    output lwfc_pkg::cmd_t  cmd
);
    import lwfc_pkg::*;

    logic [14:0] mem [SCAN_POINTS];
    logic [14:0] rd_reg;
    logic [IDX_W-1:0] raddr_reg;
    logic [IDX_W-1:0] ridx_reg;
    logic rvld_reg;
    logic [DIST_W-1:0] min_l_reg, min_c_reg, min_r_reg;
    mode_t mode_reg, mode_next;
    logic step_reg, step_next;
    side_t side_reg, side_next;
    logic [DIST_W-1:0] prev_reg, prev_next;
    cmd_t c0_reg, c1_reg, c0_next, c1_next;
    logic [1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk)
    begin
        if (ctl.store_en)
        begin
            mem[pt.point_index] <= {pt.range_valid, pt.range_mm};
        end
        rd_reg <= mem[raddr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raddr_reg <= '0;
            ridx_reg <= '0;
            rvld_reg <= 1'b0;
            min_l_reg <= NOTHING;
            min_c_reg <= NOTHING;
            min_r_reg <= NOTHING;
        end
        else if (ctl.sweep_start)
        begin
            raddr_reg <= '0;
            rvld_reg <= 1'b0;
            min_l_reg <= NOTHING;
            min_c_reg <= NOTHING;
            min_r_reg <= NOTHING;
        end
        else if (ctl.sweep_en)
        begin
            rvld_reg <= (raddr_reg != IDX_W'(SCAN_POINTS));
            ridx_reg <= raddr_reg;
            if (raddr_reg != IDX_W'(SCAN_POINTS))
            begin
                raddr_reg <= raddr_reg + 1'b1;
            end
            if (rvld_reg && rd_reg[14] && rd_reg[13:0] != '0)
            begin
                if (ridx_reg >= LEFT_LO && ridx_reg < CENTRE_LO)
                begin
                    if (rd_reg[13:0] < min_l_reg) min_l_reg <= rd_reg[13:0];
                end
                else if (ridx_reg >= RIGHT_LO && ridx_reg < RIGHT_HI)
                begin
                    if (rd_reg[13:0] < min_r_reg) min_r_reg <= rd_reg[13:0];
                end
                else if (ridx_reg >= CENTRE_LO || ridx_reg < RIGHT_LO)
                begin
                    if (rd_reg[13:0] < min_c_reg) min_c_reg <= rd_reg[13:0];
                end
            end
        end
    end

    assign sts.sweep_done = (raddr_reg == IDX_W'(SCAN_POINTS)) && !rvld_reg;
    assign sts.cmd_count = cnt_reg;
    assign cmd = ctl.sel_second ? c1_reg : c0_reg;

    function automatic cmd_t mk(input logic signed [11:0] lin, input logic signed [12:0] ang,
                                input logic [11:0] w, input logic l);
        cmd_t c;
        c.linear_speed = lin[10:0];
        c.angular_rate = ang[11:0];
        c.wait_before_ms = w;
        c.last_command = l;
        return c;
    endfunction

    always_comb
    begin
        logic [DIST_W-1:0] smallest, wd, diff;
        side_t sd;
        logic signed [11:0] cs;
        logic signed [12:0] tr, tr2;
        cs = signed'({2'b00, cfg.cruise_speed});
        tr = signed'({3'b000, cfg.yaw_rate});
        tr2 = signed'({2'b00, cfg.yaw_rate, 1'b0});
        if (side_reg == SIDE_LEFT)
        begin
            tr = -tr;
            tr2 = -tr2;
        end
        mode_next = mode_reg;
        step_next = step_reg;
        side_next = side_reg;
        c0_next = '0;
        c1_next = '0;
        cnt_next = 2'd0;
        smallest = NOTHING;
        sd = SIDE_NONE;
        if (min_l_reg < smallest) begin smallest = min_l_reg; sd = SIDE_LEFT; end
        if (min_r_reg < smallest) begin smallest = min_r_reg; sd = SIDE_RIGHT; end
        if (min_c_reg < smallest) begin smallest = min_c_reg; sd = SIDE_CENTRE; end
        unique case (side_reg)
            SIDE_LEFT: wd = min_l_reg;
            SIDE_CENTRE: wd = min_c_reg;
            SIDE_RIGHT: wd = min_r_reg;
            default: wd = NOTHING;
        endcase
        diff = (prev_reg > wd) ? prev_reg - wd : wd - prev_reg;
        if (mode_reg == MODE_STRAIGHT)
        begin
            if (sd == SIDE_NONE || smallest > cfg.track_mm)
            begin
                c0_next = mk(cs, '0, '0, 1'b1);
                cnt_next = 2'd1;
            end
            else if (smallest > cfg.guard_mm)
            begin
                mode_next = MODE_WALL;
                if (sd == SIDE_CENTRE)
                    side_next = (min_l_reg < min_r_reg) ? SIDE_LEFT : SIDE_RIGHT;
                else
                    side_next = sd;
            end
            else
            begin
                c0_next = mk(-cs, '0, '0, 1'b1);
                cnt_next = 2'd1;
            end
        end
        else if (mode_reg == MODE_CORNER)
        begin
            if (!step_reg)
            begin
                c0_next = mk('0, tr2, '0, 1'b0);
                c1_next = mk(signed'({2'b00, cfg.doorway_speed}), '0, cfg.turn_wait_ms, 1'b1);
                cnt_next = 2'd2;
                step_next = 1'b1;
            end
            else if (wd < cfg.track_mm)
            begin
                mode_next = MODE_WALL;
                step_next = 1'b0;
            end
            else
            begin
                c0_next = mk('0, -tr, '0, 1'b1);
                cnt_next = 2'd1;
            end
        end
        else
        begin
            if (min_c_reg < cfg.guard_mm)
            begin
                c0_next = mk('0, tr2, '0, 1'b1);
                cnt_next = 2'd1;
            end
            else if (diff > cfg.corner_delta)
            begin
                mode_next = MODE_CORNER;
                step_next = 1'b0;
            end
            else if (wd < cfg.guard_mm)
            begin
                c0_next = mk('0, tr, '0, 1'b1);
                cnt_next = 2'd1;
            end
            else if (wd > cfg.track_mm)
            begin
                c0_next = mk('0, -tr, '0, 1'b0);
                c1_next = mk(signed'({3'b000, cfg.cruise_speed[9:1]}), '0,
                             cfg.turn_wait_ms, 1'b1);
                cnt_next = 2'd2;
            end
            else
            begin
                c0_next = mk(cs, '0, '0, 1'b1);
                cnt_next = 2'd1;
            end
        end
        unique case (side_next)
            SIDE_LEFT: prev_next = min_l_reg;
            SIDE_CENTRE: prev_next = min_c_reg;
            SIDE_RIGHT: prev_next = min_r_reg;
            default: prev_next = prev_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_STRAIGHT;
            step_reg <= 1'b0;
            side_reg <= SIDE_NONE;
            prev_reg <= NOTHING;
            cnt_reg <= 2'd0;
        end
        else if (ctl.plan_en)
        begin
            mode_reg <= mode_next;
            step_reg <= step_next;
            side_reg <= side_next;
            prev_reg <= prev_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.plan_en)
        begin
            c0_reg <= c0_next;
            c1_reg <= c1_next;
        end
    end

endmodule

@@ rtl/lwfc_ctrl.sv @@
`timescale 1ns / 1ps
module lwfc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  lwfc_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  lwfc_pkg::point_t pt,
    output logic             out_valid,
    input  logic             out_ready,
    input  lwfc_pkg::sts_t   sts,
    output lwfc_pkg::ctl_t   ctl
);
    import lwfc_pkg::*;

    state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [3:0] reps;
    logic acc;

    assign reps = (cfg.scan_repeats == 4'd0) ? 4'd1 : cfg.scan_repeats;
    assign acc = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        ctl = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_COLLECT:
            begin
                in_ready = 1'b1;
                if (acc)
                begin
                    if (cnt_reg < reps)
                    begin
                        ctl.store_en = (pt.point_index < IDX_W'(SCAN_POINTS)) &&
                                       (cnt_reg == 4'd0 || pt.range_valid);
                        if (pt.last_point) cnt_next = cnt_reg + 1'b1;
                    end
                    else if (pt.last_point)
                    begin
                        ctl.sweep_start = 1'b1;
                        cnt_next = '0;
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP:
            begin
                ctl.sweep_en = 1'b1;
                if (sts.sweep_done) state_next = ST_PLAN;
            end
            ST_PLAN:
            begin
                ctl.plan_en = 1'b1;
                state_next = ST_OUT0;
            end
            ST_OUT0:
            begin
                if (sts.cmd_count == 2'd0)
                    state_next = ST_COLLECT;
                else
                begin
                    out_valid = 1'b1;
                    if (out_ready)
                        state_next = (sts.cmd_count == 2'd2) ? ST_OUT1 : ST_COLLECT;
                end
            end
            ST_OUT1:
            begin
                ctl.sel_second = 1'b1;
                out_valid = 1'b1;
                if (out_ready) state_next = ST_COLLECT;
            end
            default: state_next = ST_COLLECT;
        endcase
    end

endmodule

@@ rtl/lidar_wall_follow_controller_top.sv @@
`timescale 1ns / 1ps
// Lidar wall-following controller.
// in channel: one lidar point per transaction (in_valid/in_ready, in_data).
// out channel: velocity commands (out_valid/out_ready, out_data), none, one or two
//   per planning step, last_command marks the final one.
// cfg channel: cfg_valid/cfg_ready, cfg_index selects register 0..7, cfg_data.
// Points of the merged scans are taken one per cycle. On the last point of
// the planning scan the block stops taking points and walks the 360-entry
// range store, one entry per cycle through its single read port (ST_SWEEP),
// then plans (ST_PLAN) and offers the first command (ST_OUT0).
// Throughput during collection: one point per cycle. A planning step holds
// the input off while it sweeps, plans and offers its commands, and for as
// long as the receiver stalls.
// Reset restores register defaults, straight mode, no wall side and an empty
// scan count; the store content is undefined until written by a first scan.
// When the receiver stalls, the command holds and no point is accepted.
module lidar_wall_follow_controller_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lwfc_pkg::point_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output lwfc_pkg::cmd_t   out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [13:0]      cfg_data
);
    import lwfc_pkg::*;

    cfg_t cfg_reg;
    ctl_t ctl;
    sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.track_mm <= 14'd300;
            cfg_reg.guard_mm <= 14'd150;
            cfg_reg.corner_delta <= 14'd100;
            cfg_reg.cruise_speed <= 10'd50;
            cfg_reg.yaw_rate <= 10'd150;
            cfg_reg.doorway_speed <= 10'd200;
            cfg_reg.scan_repeats <= 4'd5;
            cfg_reg.turn_wait_ms <= 12'd500;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_FOLLOW: cfg_reg.track_mm <= cfg_data;
                REG_SAFE: cfg_reg.guard_mm <= cfg_data;
                REG_CORNER: cfg_reg.corner_delta <= cfg_data;
                REG_CRUISE: cfg_reg.cruise_speed <= cfg_data[9:0];
                REG_TURN: cfg_reg.yaw_rate <= cfg_data[9:0];
                REG_DOORWAY: cfg_reg.doorway_speed <= cfg_data[9:0];
                REG_REPEATS: cfg_reg.scan_repeats <= cfg_data[3:0];
                REG_WAIT: cfg_reg.turn_wait_ms <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    lwfc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_valid(in_valid), .in_ready(in_ready), .pt(in_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .sts(sts), .ctl(ctl)
    );

    lwfc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .pt(in_data),
        .ctl(ctl), .sts(sts), .cmd(out_data)
    );

endmodule

@@ rtl/lwfc_checker.sv @@
`timescale 1ns / 1ps
module lwfc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input lwfc_pkg::cmd_t   out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction dropped");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready))
        else $error("input taken while command pending");
    a_move: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.linear_speed != '0 |-> out_data.angular_rate == '0)
        else $error("command both moves and turns");
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_command |=> out_valid)
        else $error("second command missing");
endmodule

bind lidar_wall_follow_controller_top lwfc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
